[sv/ntc_lin_pkg.sv]
// Shared types, widths, codes and helpers of the NTC curve linearizer.
`default_nettype none
package ntc_lin_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CH_W   = 3;
    localparam int CODE_W = 12;
    localparam int Q_W    = 32;
    localparam int VPC_W  = 24;
    localparam int X_W    = 28;   // x in Q16.16, below 2^28
    localparam int P_W    = 31;   // x^2, x^3 after clamping
    localparam int T_W    = 48;   // one rounded term
    localparam int SUM_W  = 50;   // numerator / denominator sums
    localparam int MAG_W  = 49;   // magnitudes of the sums
    localparam int QBITS  = 33;   // quotient bits, 16 integer + 17 fraction
    localparam int ADDR_W = 5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OFF  = 2'd1;
    localparam logic [1:0] ST_DEN0 = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_N0  = 3'd0;
    localparam logic [2:0] REG_N1  = 3'd1;
    localparam logic [2:0] REG_N2  = 3'd2;
    localparam logic [2:0] REG_N3  = 3'd3;
    localparam logic [2:0] REG_D1  = 3'd4;
    localparam logic [2:0] REG_D2  = 3'd5;
    localparam logic [2:0] REG_D3  = 3'd6;
    localparam logic [2:0] REG_VPC = 3'd7;

    localparam logic [VPC_W-1:0] VPC_RESET = 24'd13519;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic              sensor_enabled;
        logic [CODE_W-1:0] adc_code;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]      result_channel;
        logic signed [Q_W-1:0] temperature;
        logic [1:0]           status;
    } out_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] n0;
        logic signed [Q_W-1:0] n1;
        logic signed [Q_W-1:0] n2;
        logic signed [Q_W-1:0] n3;
        logic signed [Q_W-1:0] d1;
        logic signed [Q_W-1:0] d2;
        logic signed [Q_W-1:0] d3;
        logic [VPC_W-1:0]      vpc;
    } cfg_t;

    // One slot of the divider chain
    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  ch;
        logic [1:0]       status;
        logic             neg;
        logic             nz;
        logic [MAG_W-1:0] d;
        logic [MAG_W-1:0] rem;
        logic [QBITS-1:0] nbits;
        logic [QBITS-1:0] q;
    } div_slot_t;

    // Signed coefficient times unsigned power, exact
    function automatic logic signed [63:0] mul_cp(input logic signed [Q_W-1:0] c,
                                                  input logic [P_W-1:0] p);
        logic signed [63:0] a;
        logic signed [63:0] b;
        begin
            a = 64'(c);
            b = $signed({33'b0, p});
            return a * b;
        end
    endfunction

    // Round Q32.32 product to Q16.16, halves toward plus infinity
    function automatic logic signed [T_W-1:0] round_q16(input logic signed [63:0] v);
        logic signed [63:0] a;
        begin
            a = v + 64'sd32768;
            a = a >>> 16;
            return a[T_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[sv/ntc_lin_regs.sv]
// APB register file holding the curve coefficients and converter gain.
`default_nettype none
module ntc_lin_regs
    import ntc_lin_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[ADDR_W-1:2];
    assign wr  = psel & penable & pwrite;
    assign cfg = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_N0:  cfg_next.n0  = $signed(pwdata);
                REG_N1:  cfg_next.n1  = $signed(pwdata);
                REG_N2:  cfg_next.n2  = $signed(pwdata);
                REG_N3:  cfg_next.n3  = $signed(pwdata);
                REG_D1:  cfg_next.d1  = $signed(pwdata);
                REG_D2:  cfg_next.d2  = $signed(pwdata);
                REG_D3:  cfg_next.d3  = $signed(pwdata);
                REG_VPC: cfg_next.vpc = pwdata[VPC_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Coefficients reset to zero, gain to its default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= {{(7*Q_W){1'b0}}, VPC_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_N0:  prdata = cfg_reg.n0;
            REG_N1:  prdata = cfg_reg.n1;
            REG_N2:  prdata = cfg_reg.n2;
            REG_N3:  prdata = cfg_reg.n3;
            REG_D1:  prdata = cfg_reg.d1;
            REG_D2:  prdata = cfg_reg.d2;
            REG_D3:  prdata = cfg_reg.d3;
            REG_VPC: prdata = {8'b0, cfg_reg.vpc};
            default: prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[sv/ntc_lin_poly.sv]
// Front pipeline: scaling, powers, coefficient terms, sums and divider setup.
`default_nettype none
module ntc_lin_poly
    import ntc_lin_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_take,
    input  in_item_t      in_item,
    input  cfg_t          cfg,
    output div_slot_t     slot
);

    // Stage valid, channel and disable flag run alongside the data
    logic [5:0]      v_reg;
    logic [CH_W-1:0] ch_reg  [6];
    logic            off_reg [6];

    logic [X_W-1:0]  x1_reg, x2s_reg, x3s_reg;
    logic [P_W-1:0]  p2_reg, p2b_reg;
    logic [P_W-1:0]  p3_reg;
    logic signed [63:0] m1n_reg, m1d_reg;
    logic signed [63:0] m2n_reg, m2d_reg, m3n_reg, m3d_reg;
    logic signed [T_W-1:0] r1n_reg, r1d_reg;
    logic signed [T_W-1:0] t1n_reg, t1d_reg, t2n_reg, t2d_reg, t3n_reg, t3d_reg;
    logic signed [SUM_W-1:0] num_reg, den_reg;
    div_slot_t slot_reg;

    logic [35:0] sc;
    logic [56:0] sq;
    logic [58:0] cb;
    logic [40:0] sq_sh;
    logic [42:0] cb_sh;
    logic [P_W-1:0] p2_c, p3_c;
    logic [MAG_W-1:0] nmag, dmag;
    logic [64:0] dlim;
    logic        den0, ovf;
    div_slot_t   slot_c;

    // Scaling and powers
    always_comb
    begin
        sc    = 36'(in_item.adc_code) * 36'(cfg.vpc) + 36'd128;
        sq    = 57'(x1_reg) * 57'(x1_reg) + 57'd32768;
        sq_sh = sq[56:16];
        p2_c  = (sq_sh > 41'h7FFFFFFF) ? 31'h7FFFFFFF : sq_sh[P_W-1:0];
        cb    = 59'(p2_reg) * 59'(x2s_reg) + 59'd32768;
        cb_sh = cb[58:16];
        p3_c  = (cb_sh > 43'h7FFFFFFF) ? 31'h7FFFFFFF : cb_sh[P_W-1:0];
    end

    // Sign, magnitude, zero and range checks ahead of the divider
    always_comb
    begin
        nmag   = num_reg[SUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
        dmag   = den_reg[SUM_W-1] ? MAG_W'(-den_reg) : MAG_W'(den_reg);
        den0   = (den_reg == '0);
        dlim   = {dmag, 16'b0};
        ovf    = (65'(nmag) >= dlim);
        slot_c = '0;
        slot_c.valid = v_reg[5];
        slot_c.ch    = ch_reg[5];
        slot_c.d     = dmag;
        slot_c.rem   = MAG_W'(nmag[MAG_W-1:16]);
        slot_c.nbits = {nmag[15:0], 17'b0};
        slot_c.nz    = (num_reg != '0);
        if (off_reg[5])
        begin
            slot_c.status = ST_OFF;
        end
        else if (den0)
        begin
            slot_c.status = ST_DEN0;
            slot_c.neg    = num_reg[SUM_W-1];
        end
        else
        begin
            slot_c.neg    = num_reg[SUM_W-1] ^ den_reg[SUM_W-1];
            slot_c.status = ovf ? ST_SAT : ST_OK;
        end
    end

    // Control: valid bits and the slot handed to the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            slot_reg <= '0;
        end
        else if (en)
        begin
            v_reg    <= {v_reg[4:0], in_take};
            slot_reg <= slot_c;
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch_reg[0]  <= in_item.channel;
            off_reg[0] <= !in_item.sensor_enabled || (int'(in_item.channel) >= CHANNELS);
            for (int i = 1; i < 6; i++)
            begin
                ch_reg[i]  <= ch_reg[i-1];
                off_reg[i] <= off_reg[i-1];
            end
            // stage 1: x
            x1_reg  <= sc[35:8];
            // stage 2: x^2
            p2_reg  <= p2_c;
            x2s_reg <= x1_reg;
            // stage 3: x^3, linear products
            p3_reg  <= p3_c;
            p2b_reg <= p2_reg;
            m1n_reg <= mul_cp(cfg.n1, P_W'(x2s_reg));
            m1d_reg <= mul_cp(cfg.d1, P_W'(x2s_reg));
            // stage 4: square and cube products
            r1n_reg <= round_q16(m1n_reg);
            r1d_reg <= round_q16(m1d_reg);
            m2n_reg <= mul_cp(cfg.n2, p2b_reg);
            m2d_reg <= mul_cp(cfg.d2, p2b_reg);
            m3n_reg <= mul_cp(cfg.n3, p3_reg);
            m3d_reg <= mul_cp(cfg.d3, p3_reg);
            // stage 5: rounding
            t1n_reg <= r1n_reg;
            t1d_reg <= r1d_reg;
            t2n_reg <= round_q16(m2n_reg);
            t2d_reg <= round_q16(m2d_reg);
            t3n_reg <= round_q16(m3n_reg);
            t3d_reg <= round_q16(m3d_reg);
            // stage 6: sums
            num_reg <= SUM_W'(cfg.n0) + SUM_W'(t1n_reg) + SUM_W'(t2n_reg)
                       + SUM_W'(t3n_reg);
            den_reg <= SUM_W'(65536) + SUM_W'(t1d_reg) + SUM_W'(t2d_reg)
                       + SUM_W'(t3d_reg);
        end
    end

    assign slot = slot_reg;

endmodule
`default_nettype wire

[sv/ntc_lin_cell.sv]
// One restoring-division cell: retires one quotient bit per item per cycle while en is high.
`default_nettype none
module ntc_lin_cell
    import ntc_lin_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  div_slot_t slot_in,
    output div_slot_t slot_out
);

    div_slot_t        slot_reg;
    div_slot_t        slot_next;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             bit_q;

    // Shift in the next numerator bit, subtract divisor if it fits
    always_comb
    begin
        trial     = {slot_in.rem, slot_in.nbits[QBITS-1]};
        diff      = trial - {1'b0, slot_in.d};
        bit_q     = (trial >= {1'b0, slot_in.d});
        slot_next = slot_in;
        slot_next.rem   = bit_q ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        slot_next.nbits = {slot_in.nbits[QBITS-2:0], 1'b0};
        slot_next.q     = {slot_in.q[QBITS-2:0], bit_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (en)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule
`default_nettype wire

[sv/ntc_rational_curve_linearizer_core.sv]
// Top level of the NTC rational-cubic linearizer: registers, pipeline, output buffer.
`default_nettype none
// Takes one converter sample per cycle and returns one temperature item per sample,
// in order. An accepted sample passes through the front pipeline (scaling, powers,
// coefficient products, sums and divider setup), then through the chain of division
// cells (one quotient bit per cell), and then the output register. The pipeline
// stalls as a whole only when both the output register and its skid entry hold
// items; until then input is taken every cycle. Coefficients must be written while
// no item is in flight.
module ntc_rational_curve_linearizer_core
    import ntc_lin_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t      cfg;
    logic      en;
    div_slot_t chain [QBITS+1];

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              skid_valid_reg, skid_valid_next;
    out_item_t         skid_reg, skid_next;
    out_item_t         fin;
    logic [QBITS:0]    mag;
    logic              sat;
    div_slot_t         last;

    assign pready   = 1'b1;
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    ntc_lin_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ntc_lin_poly #(.CHANNELS(CHANNELS)) u_poly (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_take (in_valid & en),
        .in_item (in_data),
        .cfg     (cfg),
        .slot    (chain[0])
    );

    // Division chain
    for (genvar g = 0; g < QBITS; g++)
    begin : g_cell
        ntc_lin_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .slot_in  (chain[g]),
            .slot_out (chain[g+1])
        );
    end

    assign last = chain[QBITS];

    // Final rounding and special cases
    always_comb
    begin
        mag = ({1'b0, last.q} + (QBITS+1)'(1)) >> 1;
        sat = last.neg ? (mag > (QBITS+1)'(33'h080000000))
                       : (mag > (QBITS+1)'(33'h07FFFFFFF));
        fin.result_channel = last.ch;
        fin.status         = last.status;
        case (last.status)
            ST_OFF:
            begin
                fin.temperature = '0;
            end
            ST_DEN0:
            begin
                if (!last.nz)
                    fin.temperature = '0;
                else
                    fin.temperature = last.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            ST_SAT:
            begin
                fin.temperature = last.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            default:
            begin
                if (sat)
                begin
                    fin.status      = ST_SAT;
                    fin.temperature = last.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                end
                else
                begin
                    fin.temperature = last.neg ? -$signed(mag[Q_W-1:0])
                                               : $signed(mag[Q_W-1:0]);
                end
            end
        endcase
    end

    // Output register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = en & last.valid;
                out_next       = fin;
            end
        end
        else if (en && last.valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[sv/ntc_lin_checker.sv]
// Port-level checks of the linearizer and the bind that attaches them.
`default_nettype none
module ntc_lin_checker
    import ntc_lin_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data,
    input wire logic      pready
);

    // A waiting item stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item dropped or changed while stalled");

    // Disabled channel reads zero
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OFF |-> out_data.temperature == 0)
        else $error("disabled channel with nonzero temperature");

    // Zero denominator gives a rail or zero
    a_den0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_DEN0 |->
        out_data.temperature == 32'sh7FFFFFFF || out_data.temperature == 32'sh80000000
        || out_data.temperature == 0)
        else $error("zero denominator without rail value");

    // Saturation lands on a rail
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_SAT |->
        out_data.temperature == 32'sh7FFFFFFF || out_data.temperature == 32'sh80000000)
        else $error("saturated item off the rails");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready dropped");

endmodule

bind ntc_rational_curve_linearizer_core ntc_lin_checker u_ntc_lin_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);
`default_nettype wire

[dv/ntc_rational_curve_linearizer_core_tb.sv]
// Testbench of the NTC rational-cubic linearizer: random stimulus, fixed-point predictor.
module ntc_rational_curve_linearizer_core_tb;
    import ntc_lin_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ntc_rational_curve_linearizer_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Shadow copy of the curve registers
    logic signed [31:0] coef [7];
    logic [VPC_W-1:0] vpc;

    in_item_t sample_q[$];
    out_item_t temp_q[$];
    int errors = 0;
    bit quiet = 1'b0;
    bit in_took = 1'b0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic longint rnd16(input longint v);
        longint a;
        a = v + 32768;
        return a >>> 16;
    endfunction

    function automatic out_item_t linearize(input in_item_t s);
        out_item_t r;
        longint unsigned x, x2, x3, n, d, qi, rem, q, mag;
        longint num, den;
        bit neg, sat;
        r.result_channel = s.channel;
        r.temperature = '0;
        r.status = ST_OK;
        if (!s.sensor_enabled || s.channel >= CHANNELS_DEF) begin
            r.status = ST_OFF;
            return r;
        end
        x = (longint'(s.adc_code) * vpc + 128) >> 8;
        x2 = (x * x + 32768) >> 16;
        if (x2 > 64'h7FFFFFFF) x2 = 64'h7FFFFFFF;
        x3 = (x2 * x + 32768) >> 16;
        if (x3 > 64'h7FFFFFFF) x3 = 64'h7FFFFFFF;
        num = longint'(coef[0]) + rnd16(coef[1] * longint'(x))
            + rnd16(coef[2] * longint'(x2)) + rnd16(coef[3] * longint'(x3));
        den = 65536 + rnd16(coef[4] * longint'(x))
            + rnd16(coef[5] * longint'(x2)) + rnd16(coef[6] * longint'(x3));
        if (den == 0) begin
            r.status = ST_DEN0;
            r.temperature = num > 0 ? 32'h7FFFFFFF : (num < 0 ? 32'h80000000 : 32'h0);
            return r;
        end
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        qi = n / d;
        rem = n % d;
        sat = 1'b0;
        mag = 0;
        if (qi >= 65536) sat = 1'b1;
        else begin
            q = qi;
            for (int i = 0; i < 17; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q = q | 1;
                end
            end
            mag = (q + 1) >> 1;
            if (neg ? mag > 64'h80000000 : mag > 64'h7FFFFFFF) sat = 1'b1;
        end
        if (sat) begin
            r.status = ST_SAT;
            r.temperature = neg ? 32'h80000000 : 32'h7FFFFFFF;
        end else
            r.temperature = 32'(neg ? -mag : mag);
        return r;
    endfunction

    // Driver: presents items from the pending queue with random bursts of idle, records expectations, stalls the output
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_took) begin
                temp_q.push_back(linearize(in_data));
                void'(sample_q.pop_front());
                if (!quiet && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 19);
            end
            if (!in_valid || in_took) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= sample_q[0];
                end else
                    in_valid <= 1'b0;
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 19);
            end
        end
    end

    // Monitor: notes input accepts and checks each result against the oldest expectation
    always @(posedge clk) begin
        in_took = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready) begin
            if (temp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, out_data);
            end else begin
                if (out_data !== temp_q[0]) begin
                    errors++;
                    $display("%0t: mismatch expected ch %0d t %h st %0d, actual ch %0d t %h st %0d",
                        $time, temp_q[0].result_channel, temp_q[0].temperature,
                        temp_q[0].status, out_data.result_channel, out_data.temperature,
                        out_data.status);
                end
                void'(temp_q.pop_front());
            end
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_VPC) vpc = val[VPC_W-1:0];
        else coef[idx] = val;
    endtask

    task automatic drain_pipe;
        while (sample_q.size() > 0 || in_valid || temp_q.size() > 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic in_item_t rand_sample(input bit edges);
        in_item_t s;
        s.channel = CH_W'($urandom_range(0, 7));
        s.sensor_enabled = $urandom_range(0, 9) != 0;
        case (edges ? $urandom_range(0, 3) : 3)
            0: s.adc_code = 12'd0;
            1: s.adc_code = 12'hFFF;
            2: s.adc_code = CODE_W'($urandom_range(0, 15));
            default: s.adc_code = CODE_W'($urandom_range(0, 4095));
        endcase
        return s;
    endfunction

    // Curve settings: extremes, fully random words, moderate and small coefficients
    task automatic load_curve(input int kind);
        for (int i = 0; i < 7; i++) begin
            case (kind)
                0: reg_write(i, $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
                1: reg_write(i, $urandom());
                2: reg_write(i, $signed($urandom_range(0, 131072)) - 65536);
                default: reg_write(i, $signed($urandom_range(0, 2048)) - 1024);
            endcase
        end
        case (kind)
            0: reg_write(REG_VPC, $urandom_range(0, 1) ? 32'hFFFFFF : 32'h0);
            1: reg_write(REG_VPC, $urandom_range(0, 24'hFFFFFF));
            default: reg_write(REG_VPC, $urandom_range(1000, 40000));
        endcase
    endtask

    initial begin
        in_item_t s;
        for (int i = 0; i < 7; i++) coef[i] = '0;
        vpc = VPC_RESET;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset curve, then denominator zero with each numerator sign
        for (int c = 0; c < 8; c++) begin
            s.channel = CH_W'(c);
            s.sensor_enabled = c[0];
            s.adc_code = c[1] ? 12'hFFF : 12'h0;
            sample_q.push_back(s);
        end
        drain_pipe();
        reg_write(REG_D1, 32'hFFFF0000);   // den = 1 - x
        reg_write(REG_VPC, 24'h010000);    // x = code/256 volts
        for (int k = 0; k < 3; k++) begin
            reg_write(REG_N0, k == 0 ? 32'd65536 : (k == 1 ? -32'sd65536 : 32'd0));
            s.channel = 3'd1;
            s.sensor_enabled = 1'b1;
            s.adc_code = 12'd256;          // x = 1.0
            sample_q.push_back(s);
            s.adc_code = 12'd255;          // near pole, large quotient
            sample_q.push_back(s);
            s.adc_code = 12'd257;
            sample_q.push_back(s);
            drain_pipe();
        end
        load_curve(0);
        for (int i = 0; i < 6; i++) sample_q.push_back(rand_sample(1'b1));
        drain_pipe();

        // Random phases over several curve settings
        for (int ph = 0; ph < 16; ph++) begin
            load_curve(ph % 4);
            if (ph == 14) quiet = 1'b1;
            for (int i = 0; i < 100; i++) sample_q.push_back(rand_sample(i < 10));
            drain_pipe();
        end

        if (errors == 0)
            $display("ntc_rational_curve_linearizer_core regression: pass");
        else
            $display("ntc_rational_curve_linearizer_core regression: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("ntc_rational_curve_linearizer_core regression: fail");
        $finish;
    end

endmodule
